[src/vwft_pkg.sv]
`default_nettype none
package vwft_pkg;

    // Operation codes carried on the func field
    localparam logic [2:0] FUNC_TICK      = 3'd0;
    localparam logic [2:0] FUNC_WRITE_CTL = 3'd1;
    localparam logic [2:0] FUNC_CLEAR_ST  = 3'd2;
    localparam logic [2:0] FUNC_DEC_EXP   = 3'd3;
    localparam logic [2:0] FUNC_READ_ST   = 3'd4;

    // Final expiry action codes
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_NOTIFY  = 2'd1;
    localparam logic [1:0] ACT_STOP    = 2'd2;
    localparam logic [1:0] ACT_RESTART = 2'd3;

    // One input item
    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] timebase;
        logic [5:0]  fit_period_code;
        logic [5:0]  wd_period_code;
        logic [1:0]  reset_ctl;
        logic        wd_int_enable;
        logic        fit_int_enable;
        logic        dec_int_enable;
        logic        clear_dis;
        logic        clear_fis;
        logic        clear_wis;
        logic        clear_enw;
    } req_t;

    // One result item
    typedef struct packed {
        logic       fit_irq;
        logic       wd_irq;
        logic       dec_irq;
        logic [1:0] wd_action_out;
        logic       status_dis;
        logic       status_fis;
        logic       status_wis;
        logic       status_enw;
        logic [1:0] reset_status;
        logic [5:0] hw_period_code;
    } res_t;

endpackage
`default_nettype wire

[src/vwft_core.sv]
`default_nettype none
module vwft_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          advance,
    input  wire vwft_pkg::req_t req,
    input  wire logic [1:0]    expiry_action,
    output vwft_pkg::res_t     res
);
    import vwft_pkg::*;

    logic [63:0] prev_tb_reg, prev_tb_next;
    logic [5:0]  fit_code_reg, fit_code_next;
    logic [5:0]  wd_code_reg, wd_code_next;
    logic [5:0]  hw_code_reg, hw_code_next;
    logic [1:0]  rst_ctl_reg, rst_ctl_next;
    logic [1:0]  saved_rst_reg, saved_rst_next;
    // enables: die, fie, wie
    logic        die_reg, die_next, fie_reg, fie_next, wie_reg, wie_next;
    // status: dis, fis, wis, enw
    logic        dis_reg, dis_next, fis_reg, fis_next;
    logic        wis_reg, wis_next, enw_reg, enw_next;

    logic [5:0]  fit_bit, wd_bit, hw_bit;
    logic        fit_rose, wd_rose;
    logic        fit_irq, wd_irq, dec_irq;
    logic [1:0]  action;

    // Watched bit index is 63 minus code, i.e. the inverted code
    assign fit_bit = ~fit_code_reg;
    assign wd_bit  = ~wd_code_reg;
    assign hw_bit  = ~hw_code_reg;

    // Rising edge of the watched bit, hardware period bit masked from the old value
    assign fit_rose = !((fit_bit != hw_bit) && prev_tb_reg[fit_bit]) && req.timebase[fit_bit];
    assign wd_rose  = !((wd_bit != hw_bit) && prev_tb_reg[wd_bit]) && req.timebase[wd_bit];

    // Next state and result
    always_comb begin
        prev_tb_next   = prev_tb_reg;
        fit_code_next  = fit_code_reg;
        wd_code_next   = wd_code_reg;
        hw_code_next   = hw_code_reg;
        rst_ctl_next   = rst_ctl_reg;
        saved_rst_next = saved_rst_reg;
        die_next       = die_reg;
        fie_next       = fie_reg;
        wie_next       = wie_reg;
        dis_next       = dis_reg;
        fis_next       = fis_reg;
        wis_next       = wis_reg;
        enw_next       = enw_reg;
        fit_irq        = 1'b0;
        wd_irq         = 1'b0;
        dec_irq        = 1'b0;
        action         = ACT_NONE;
        case (req.func)
            FUNC_TICK: begin
                if (fit_rose) begin
                    fis_next = 1'b1;
                    fit_irq  = fie_reg;
                end
                if (wd_rose) begin
                    case ({enw_reg, wis_reg})
                        2'b00: enw_next = 1'b1;
                        2'b10: begin
                            wis_next = 1'b1;
                            wd_irq   = wie_reg;
                        end
                        2'b01: enw_next = 1'b1;
                        default: begin
                            // final expiry
                            if (rst_ctl_reg != 2'd0) begin
                                action = expiry_action;
                                if (expiry_action == ACT_RESTART)
                                    saved_rst_next = rst_ctl_reg;
                            end
                        end
                    endcase
                end
                prev_tb_next = req.timebase;
            end
            FUNC_WRITE_CTL: begin
                fit_code_next = req.fit_period_code;
                wd_code_next  = req.wd_period_code;
                if (rst_ctl_reg == 2'd0)
                    rst_ctl_next = req.reset_ctl;
                wie_next = req.wd_int_enable;
                fie_next = req.fit_int_enable;
                die_next = req.dec_int_enable;
                // re-raise pending interrupts
                wd_irq   = req.wd_int_enable && wis_reg;
                fit_irq  = req.fit_int_enable && fis_reg;
                dec_irq  = req.dec_int_enable && dis_reg;
                hw_code_next = (req.fit_period_code > req.wd_period_code) ?
                               req.fit_period_code : req.wd_period_code;
            end
            FUNC_CLEAR_ST: begin
                if (req.clear_dis) dis_next = 1'b0;
                if (req.clear_fis) fis_next = 1'b0;
                if (req.clear_wis) wis_next = 1'b0;
                if (req.clear_enw) enw_next = 1'b0;
                saved_rst_next = 2'd0;
            end
            FUNC_DEC_EXP: begin
                dis_next = 1'b1;
                dec_irq  = 1'b1;
            end
            default: begin
                // read status and unused codes leave state alone
            end
        endcase

        res.fit_irq        = fit_irq;
        res.wd_irq         = wd_irq;
        res.dec_irq        = dec_irq;
        res.wd_action_out  = action;
        res.status_dis     = dis_next;
        res.status_fis     = fis_next;
        res.status_wis     = wis_next;
        res.status_enw     = enw_next;
        res.reset_status   = saved_rst_next;
        res.hw_period_code = hw_code_next;
    end

    // State update on each item leaving the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_tb_reg   <= '0;
            fit_code_reg  <= '0;
            wd_code_reg   <= '0;
            hw_code_reg   <= '0;
            rst_ctl_reg   <= '0;
            saved_rst_reg <= '0;
            die_reg       <= 1'b0;
            fie_reg       <= 1'b0;
            wie_reg       <= 1'b0;
            dis_reg       <= 1'b0;
            fis_reg       <= 1'b0;
            wis_reg       <= 1'b0;
            enw_reg       <= 1'b0;
        end else if (advance) begin
            prev_tb_reg   <= prev_tb_next;
            fit_code_reg  <= fit_code_next;
            wd_code_reg   <= wd_code_next;
            hw_code_reg   <= hw_code_next;
            rst_ctl_reg   <= rst_ctl_next;
            saved_rst_reg <= saved_rst_next;
            die_reg       <= die_next;
            fie_reg       <= fie_next;
            wie_reg       <= wie_next;
            dis_reg       <= dis_next;
            fis_reg       <= fis_next;
            wis_reg       <= wis_next;
            enw_reg       <= enw_next;
        end
    end

endmodule
`default_nettype wire

[src/virtual_watchdog_fit_timer_top.sv]
// Virtual watchdog and fixed-interval timer, one guest core.
// Flow: an item passes the input register, then the result register, where its result
// waits while m_ready holds it.
// Throughput: one item per cycle unless m_ready stalls; the state update is one compare-and-select pass.
// Reset: aresetn is synchronous, active low; it clears all timer state, the
// expiry action register and both valid flags.
`default_nettype none
module virtual_watchdog_fit_timer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    // input items
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [63:0] s_timebase,
    input  wire logic [5:0]  s_fit_period_code,
    input  wire logic [5:0]  s_wd_period_code,
    input  wire logic [1:0]  s_reset_ctl,
    input  wire logic        s_wd_int_enable,
    input  wire logic        s_fit_int_enable,
    input  wire logic        s_dec_int_enable,
    input  wire logic        s_clear_dis,
    input  wire logic        s_clear_fis,
    input  wire logic        s_clear_wis,
    input  wire logic        s_clear_enw,
    // result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_fit_irq,
    output logic             m_wd_irq,
    output logic             m_dec_irq,
    output logic [1:0]       m_wd_action_out,
    output logic             m_status_dis,
    output logic             m_status_fis,
    output logic             m_status_wis,
    output logic             m_status_enw,
    output logic [1:0]       m_reset_status,
    output logic [5:0]       m_hw_period_code
);
    import vwft_pkg::*;

    logic [1:0] expiry_action_reg;
    logic       in_valid_reg;
    req_t       in_req_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;
    res_t       core_res;
    logic       advance;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expiry_action_reg <= ACT_NONE;
        end else if (cfg_valid) begin
            expiry_action_reg <= cfg_data;
        end
    end

    // Item moves to the result register when that register is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg.func            <= s_func;
            in_req_reg.timebase        <= s_timebase;
            in_req_reg.fit_period_code <= s_fit_period_code;
            in_req_reg.wd_period_code  <= s_wd_period_code;
            in_req_reg.reset_ctl       <= s_reset_ctl;
            in_req_reg.wd_int_enable   <= s_wd_int_enable;
            in_req_reg.fit_int_enable  <= s_fit_int_enable;
            in_req_reg.dec_int_enable  <= s_dec_int_enable;
            in_req_reg.clear_dis       <= s_clear_dis;
            in_req_reg.clear_fis       <= s_clear_fis;
            in_req_reg.clear_wis       <= s_clear_wis;
            in_req_reg.clear_enw       <= s_clear_enw;
        end
    end

    vwft_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .req           (in_req_reg),
        .expiry_action (expiry_action_reg),
        .res           (core_res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_fit_irq        = out_res_reg.fit_irq;
    assign m_wd_irq         = out_res_reg.wd_irq;
    assign m_dec_irq        = out_res_reg.dec_irq;
    assign m_wd_action_out  = out_res_reg.wd_action_out;
    assign m_status_dis     = out_res_reg.status_dis;
    assign m_status_fis     = out_res_reg.status_fis;
    assign m_status_wis     = out_res_reg.status_wis;
    assign m_status_enw     = out_res_reg.status_enw;
    assign m_reset_status   = out_res_reg.reset_status;
    assign m_hw_period_code = out_res_reg.hw_period_code;

endmodule
`default_nettype wire

[src/vwft_checker.sv]
`default_nettype none
module vwft_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_fit_irq,
    input wire logic       m_wd_irq,
    input wire logic       m_dec_irq,
    input wire logic [1:0] m_wd_action_out,
    input wire logic       m_status_dis,
    input wire logic       m_status_fis,
    input wire logic       m_status_wis,
    input wire logic [1:0] m_reset_status
);
    import vwft_pkg::*;

    // A stalled result stays valid and keeps its DIS and reset status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status_dis) && $stable(m_reset_status))
        else $error("stalled result changed");

    // Each interrupt request comes with its status bit set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fit_irq |-> m_status_fis)
        else $error("fit request without FIS");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_wd_irq |-> m_status_wis)
        else $error("watchdog request without WIS");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dec_irq |-> m_status_dis)
        else $error("decrementer request without DIS");

    // A restart saves a nonzero reset control
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_wd_action_out == ACT_RESTART) |-> (m_reset_status != 2'd0))
        else $error("restart without saved reset control");

endmodule

bind virtual_watchdog_fit_timer_top vwft_checker u_vwft_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_fit_irq       (m_fit_irq),
    .m_wd_irq        (m_wd_irq),
    .m_dec_irq       (m_dec_irq),
    .m_wd_action_out (m_wd_action_out),
    .m_status_dis    (m_status_dis),
    .m_status_fis    (m_status_fis),
    .m_status_wis    (m_status_wis),
    .m_reset_status  (m_reset_status)
);
`default_nettype wire
